@@ rtl/core/pfba_pkg.sv @@
// Package for the page frame bitmap allocator.
// Holds request and status codes, sequencer states and sizing constants; no dependencies.
package pfba_pkg;

    localparam int MAP_WORDS_DEF   = 1024;
    localparam int RANGE_SLOTS_DEF = 5;
    localparam int PAGE_W          = 20;

    typedef enum logic [2:0] {
        REQ_CLEAR    = 3'd0,
        REQ_REGISTER = 3'd1,
        REQ_BUILD    = 3'd2,
        REQ_RESERVE  = 3'd3,
        REQ_ALLOC    = 3'd4,
        REQ_FREE     = 3'd5,
        REQ_NOP6     = 3'd6,
        REQ_NOP7     = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOFRAME = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RANGE,
        S_RD,
        S_WAIT,
        S_MOD,
        S_ZERO_RD,
        S_ZERO_WAIT,
        S_ZERO_WR,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/pfba_word_unit.sv @@
// Shared word unit: builds the mask of bits from lo to hi inside one bitmap word
// and finds the lowest free bit within that mask. Uses pfba_pkg.
module pfba_word_unit (
    input  logic [31:0] word,
    input  logic [4:0]  lo,
    input  logic [4:0]  hi,
    output logic [31:0] mask,
    output logic        found,
    output logic [4:0]  first_bit
);
    import pfba_pkg::*;

    logic [31:0] hit;

    always_comb
    begin
        mask = (32'hffffffff << lo) & (32'hffffffff >> (5'd31 - hi));
        hit = word & mask;
        found = |hit;
        first_bit = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_bit = 5'(i);
            end
        end
    end

endmodule

@@ rtl/core/pfba_bitmap_ram.sv @@
// Bitmap memory: one write port and one registered read port.
// Depends on nothing but its parameter.
module pfba_bitmap_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [31:0]              rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/page_frame_bitmap_allocator.sv @@
// Top level of the page frame bitmap allocator: request sequencer, range table,
// bitmap memory and shared word unit. Uses pfba_pkg, pfba_bitmap_ram, pfba_word_unit.
//
// Channel   Direction  Handshake            Word
// request   in         start high, busy low req_type, first_addr, last_addr
// result    out        done strobe, 1 cycle status, frame_addr
//
// A request walks bitmap words one at a time; each word passes through the read,
// memory wait and modify states (S_RD, S_WAIT, S_MOD), each range walked adds
// an S_RANGE step, and every request ends in S_DONE.
// Allocate skips words whose free bits are all zero.
// Reset and the clear request sweep the memory one word a cycle, with busy high.
// The receiver cannot stall; done lasts one cycle.
module page_frame_bitmap_allocator #(
    parameter int MAP_WORDS   = pfba_pkg::MAP_WORDS_DEF,
    parameter int RANGE_SLOTS = pfba_pkg::RANGE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [31:0] first_addr,
    input  logic [31:0] last_addr,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] frame_addr
);
    import pfba_pkg::*;

    localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SW       = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int CW       = $clog2(RANGE_SLOTS + 1);
    localparam int PW       = 33;
    localparam logic [PW-1:0] MAP_PAGES = PW'(MAP_WORDS) * PW'(32);

    state_t state_reg, state_next;
    logic [2:0]        kind_reg, kind_next;
    logic [PW-1:0]     p_reg, p_next;
    logic [PW-1:0]     lastp_reg, lastp_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       addr_reg, addr_next;
    logic              done_reg, done_next;
    logic [PAGE_W-1:0] rfirst_reg [RANGE_SLOTS];
    logic [PAGE_W-1:0] rlast_reg  [RANGE_SLOTS];

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [31:0]       wdata, rdata;
    logic [31:0]       mask;
    logic              found;
    logic [4:0]        first_bit;
    logic [4:0]        lo, hi;
    logic [PW-1:0]     word_end;
    logic              reg_wr;
    logic [PAGE_W-1:0] reg_first, reg_last;
    logic [31:0]       start_b, end_b;

    pfba_bitmap_ram #(.DEPTH(MAP_WORDS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    pfba_word_unit u_word (
        .word(rdata), .lo(lo), .hi(hi), .mask(mask), .found(found), .first_bit(first_bit)
    );

    assign word_end = p_reg | PW'(31);
    assign lo = p_reg[4:0];
    assign hi = (word_end > lastp_reg) ? lastp_reg[4:0] : 5'd31;
    assign start_b = (|first_addr[11:0]) ? ((first_addr & 32'hfffff000) + 32'h1000)
                                         : first_addr;
    assign end_b = (last_addr - 32'h0fff) & 32'hfffff000;

    function automatic logic [PW-1:0] clamp(input logic [PW-1:0] v);
        return (v >= MAP_PAGES) ? MAP_PAGES - PW'(1) : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            count_reg  <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            kind_reg   <= REQ_NOP7;
            slot_reg   <= '0;
            status_reg <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            kind_reg   <= kind_next;
            slot_reg   <= slot_next;
            status_reg <= status_next;
            addr_reg   <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        lastp_reg <= lastp_next;
        if (reg_wr)
        begin
            rfirst_reg[count_reg[SW-1:0]] <= reg_first;
            rlast_reg[count_reg[SW-1:0]]  <= reg_last;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        p_next      = p_reg;
        lastp_next  = lastp_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        waddr       = p_reg[AW+4:5];
        wdata       = rdata;
        raddr       = p_reg[AW+4:5];
        reg_wr      = 1'b0;
        reg_first   = start_b[31:12];
        reg_last    = end_b[31:12];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req_type;
                    status_next = ST_OK;
                    addr_next   = '0;
                    slot_next   = '0;
                    unique case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        REQ_REGISTER:
                        begin
                            state_next = S_DONE;
                            if (count_reg >= CW'(RANGE_SLOTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (last_addr < 32'h0fff || first_addr > 32'hfffff000
                                     || start_b > end_b)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                reg_wr     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_BUILD, REQ_ALLOC:
                        begin
                            state_next = S_RANGE;
                        end
                        REQ_RESERVE:
                        begin
                            p_next     = PW'(first_addr[31:12]);
                            lastp_next = clamp(PW'(last_addr[31:12]));
                            state_next = S_RD;
                        end
                        REQ_FREE:
                        begin
                            p_next     = PW'(first_addr[31:12]);
                            lastp_next = clamp(PW'(first_addr[31:12]));
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_WORDS - 1))
                begin
                    clr_next   = '0;
                    state_next = (kind_reg == REQ_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_RANGE:
            begin
                if (CW'(slot_reg) >= count_reg)
                begin
                    if (kind_reg == REQ_ALLOC)
                    begin
                        status_next = ST_NOFRAME;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ZERO_RD;
                    end
                end
                else
                begin
                    p_next     = PW'(rfirst_reg[slot_reg]);
                    lastp_next = clamp(PW'(rlast_reg[slot_reg]));
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (p_reg > lastp_reg)
                begin
                    if (kind_reg == REQ_BUILD || kind_reg == REQ_ALLOC)
                    begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = S_RANGE;
                        if (CW'(slot_reg) == CW'(RANGE_SLOTS - 1))
                        begin
                            state_next = (kind_reg == REQ_ALLOC) ? S_DONE : S_ZERO_RD;
                            if (kind_reg == REQ_ALLOC)
                            begin
                                status_next = ST_NOFRAME;
                            end
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                state_next = S_RD;
                p_next     = word_end + PW'(1);
                if (kind_reg == REQ_ALLOC)
                begin
                    if (found)
                    begin
                        we          = 1'b1;
                        wdata       = rdata & ~(32'd1 << first_bit);
                        addr_next   = {p_reg[19:5], first_bit, 12'h000};
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    we    = 1'b1;
                    wdata = (kind_reg == REQ_RESERVE) ? (rdata & ~mask) : (rdata | mask);
                end
            end
            S_ZERO_RD:
            begin
                raddr      = '0;
                state_next = S_ZERO_WAIT;
            end
            S_ZERO_WAIT:
            begin
                raddr      = '0;
                state_next = S_ZERO_WR;
            end
            S_ZERO_WR:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = rdata & ~32'd1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign frame_addr = addr_reg;

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held for two cycles");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result given while still busy");
    a_addr_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && kind_reg != REQ_ALLOC |-> frame_addr == '0)
        else $error("frame address on a request that is not an allocate");
    a_noframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_NOFRAME |-> frame_addr == '0)
        else $error("frame address given with no free frame");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for page_frame_bitmap_allocator: directed and random requests,
// each predicted by a bit-accurate behavioral copy of the frame map and the range table.
// Depends on pfba_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfba_pkg::*;

    localparam int WORDS = MAP_WORDS_DEF;
    localparam int SLOTS = RANGE_SLOTS_DEF;
    localparam int unsigned MAP_PAGES = WORDS * 32;
    localparam logic [31:0] PAGE_MASK = 32'hffff_f000;
    localparam logic [31:0] OFFSET_MASK = 32'h0000_0fff;
    localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;

    typedef struct packed {
        status_t     st;
        logic [31:0] addr;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [31:0] first_addr;
    logic [31:0] last_addr;
    logic        done;
    logic [1:0]  status;
    logic [31:0] frame_addr;

    logic [31:0] map_words [WORDS];
    logic [19:0] span_lo [SLOTS];
    logic [19:0] span_hi [SLOTS];
    int unsigned span_count;

    reply_t      pending_replies [$];
    int          errors;
    int          words_sent;
    int          frames_granted;
    int          no_frame_seen;
    bit          quiet_sender;

    page_frame_bitmap_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .first_addr (first_addr),
        .last_addr  (last_addr),
        .done       (done),
        .status     (status),
        .frame_addr (frame_addr)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d replies outstanding.", pending_replies.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("Mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    function automatic int unsigned clamp_page(input int unsigned p);
        return (p >= MAP_PAGES) ? MAP_PAGES - 1 : p;
    endfunction

    function automatic void mark_page(input int unsigned p, input bit is_free);
        if (p < MAP_PAGES)
            map_words[p >> 5][p & 31] = is_free;
    endfunction

    function automatic void wipe_model();
        foreach (map_words[i])
            map_words[i] = '0;
        foreach (span_lo[i])
        begin
            span_lo[i] = '0;
            span_hi[i] = '0;
        end
        span_count = 0;
    endfunction

    function automatic status_t add_span(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] s;
        logic [31:0] e;
        if (span_count >= SLOTS)
            return ST_FULL;
        if (hi < OFFSET_MASK || lo > PAGE_MASK)
            return ST_EMPTY;
        s = ((lo & OFFSET_MASK) != 0) ? (lo & PAGE_MASK) + PAGE_BYTES : lo;
        e = (hi - OFFSET_MASK) & PAGE_MASK;
        if (s > e)
            return ST_EMPTY;
        span_lo[span_count] = s[31:12];
        span_hi[span_count] = e[31:12];
        span_count++;
        return ST_OK;
    endfunction

    function automatic void fill_spans();
        int unsigned top;
        for (int unsigned i = 0; i < span_count; i++)
        begin
            top = clamp_page(span_hi[i]);
            for (int unsigned p = span_lo[i]; p <= top; p++)
                mark_page(p, 1'b1);
        end
        map_words[0][0] = 1'b0;
    endfunction

    function automatic bit take_frame(output logic [31:0] addr);
        int unsigned top;
        int unsigned p;
        addr = '0;
        for (int unsigned i = 0; i < span_count; i++)
        begin
            top = clamp_page(span_hi[i]);
            p = span_lo[i];
            while (p <= top)
            begin
                if (map_words[p >> 5] == '0)
                    p = (p | 31) + 1;
                else if (map_words[p >> 5][p & 31])
                begin
                    map_words[p >> 5][p & 31] = 1'b0;
                    addr = p << 12;
                    return 1'b1;
                end
                else
                    p++;
            end
        end
        return 1'b0;
    endfunction

    function automatic reply_t predict_reply(input req_t kind, input logic [31:0] a,
                                             input logic [31:0] b);
        reply_t r;
        int unsigned top;
        r.st = ST_OK;
        r.addr = '0;
        case (kind)
            REQ_CLEAR: wipe_model();
            REQ_REGISTER: r.st = add_span(a, b);
            REQ_BUILD: fill_spans();
            REQ_RESERVE:
            begin
                top = clamp_page(b >> 12);
                for (int unsigned p = a >> 12; p <= top; p++)
                    mark_page(p, 1'b0);
            end
            REQ_ALLOC:
                if (!take_frame(r.addr))
                begin
                    r.st = ST_NOFRAME;
                    r.addr = '0;
                end
            REQ_FREE: mark_page(a >> 12, 1'b1);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(input req_t kind, input logic [31:0] a, input logic [31:0] b);
        reply_t r;
        @(negedge clk);
        start = 1'b1;
        req_type = kind;
        first_addr = a;
        last_addr = b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_reply(kind, a, b);
        pending_replies.push_back(r);
        words_sent++;
        if (kind == REQ_ALLOC)
        begin
            if (r.st == ST_OK)
                frames_granted++;
            else
                no_frame_seen++;
        end
        if (!quiet_sender && $urandom_range(99) < 22)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(5)) @(negedge clk);
        end
    endtask

    task automatic drain_replies();
        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("Unexpected reply at %0t", $realtime);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (frame_addr !== want.addr)
                    report_mismatch("frame_addr", frame_addr, want.addr);
            end
        end
    end

    task automatic test_alignment();
        send_word(REQ_ALLOC, 32'h0, 32'h0);
        send_word(REQ_REGISTER, 32'h0, 32'h0);
        send_word(REQ_REGISTER, 32'hffff_f001, 32'hffff_ffff);
        send_word(REQ_REGISTER, 32'h0000_1001, 32'h0000_1fff);
        send_word(REQ_REGISTER, 32'h0, 32'h0000_0fff);
        send_word(REQ_REGISTER, 32'h0000_1000, 32'h0000_4fff);
        send_word(REQ_REGISTER, 32'h07ff_0000, 32'hffff_ffff);
        send_word(REQ_REGISTER, 32'h0000_3001, 32'h0000_8ffe);
    endtask

    task automatic test_table_full();
        send_word(REQ_REGISTER, 32'h0001_0000, 32'h0001_ffff);
        send_word(REQ_REGISTER, 32'h0002_0000, 32'h0002_ffff);
    endtask

    task automatic test_build_alloc_free();
        send_word(REQ_BUILD, 32'h0, 32'h0);
        send_word(REQ_ALLOC, 32'h0, 32'h0);
        send_word(REQ_FREE, 32'h0, 32'h0);
        send_word(REQ_ALLOC, 32'h0, 32'h0);
        send_word(REQ_FREE, 32'hffff_ffff, 32'h0);
        send_word(REQ_FREE, 32'h07ff_f123, 32'h0);
    endtask

    task automatic test_reserve_and_unknown();
        send_word(REQ_RESERVE, 32'h0000_2000, 32'h0000_3fff);
        send_word(REQ_RESERVE, 32'h0000_9000, 32'h0000_1000);
        send_word(REQ_RESERVE, 32'h07ff_8000, 32'hffff_ffff);
        send_word(REQ_ALLOC, 32'h0, 32'h0);
        send_word(REQ_NOP6, 32'hffff_ffff, 32'hffff_ffff);
        send_word(REQ_NOP7, 32'h5555_aaaa, 32'haaaa_5555);
        send_word(REQ_CLEAR, 32'h0, 32'h0);
        send_word(REQ_ALLOC, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(input int target);
        int session;
        logic [31:0] a;
        logic [31:0] b;
        int pick;
        session = 0;
        while (words_sent < target)
        begin
            quiet_sender = (session == 3 || session == 4);
            if (session == 6)
                drain_replies();
            if ($urandom_range(3) == 0)
                send_word(REQ_CLEAR, $urandom, $urandom);
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(9) == 0)
                begin
                    a = $urandom;
                    b = $urandom;
                end
                else
                begin
                    a = $urandom_range(32'h0020_0000);
                    b = a + $urandom_range(32'h0004_0000);
                end
                send_word(REQ_REGISTER, a, b);
            end
            send_word(REQ_BUILD, $urandom, $urandom);
            repeat ($urandom_range(20, 40))
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_word(REQ_ALLOC, $urandom, $urandom);
                else if (pick < 65)
                    send_word(REQ_FREE, $urandom_range(32'h0025_0000), $urandom);
                else if (pick < 75)
                begin
                    a = $urandom_range(32'h0020_0000);
                    send_word(REQ_RESERVE, a, a + $urandom_range(32'h0000_8000));
                end
                else if (pick < 78)
                    send_word(REQ_RESERVE, $urandom, $urandom);
                else
                begin
                    a = $urandom;
                    b = $urandom;
                    pick = $urandom_range(7);
                    if (pick == REQ_CLEAR && $urandom_range(3) != 0)
                        pick = REQ_NOP6;
                    send_word(req_t'(pick), a, b);
                end
            end
            session++;
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_CLEAR;
        first_addr = '0;
        last_addr = '0;
        errors = 0;
        words_sent = 0;
        frames_granted = 0;
        no_frame_seen = 0;
        quiet_sender = 1'b0;
        wipe_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_alignment();
        test_table_full();
        test_build_alloc_free();
        test_reserve_and_unknown();
        test_random_traffic(500);
        drain_replies();
        repeat (20) @(posedge clk);
        $display("Sent %0d request words; %0d frames granted, %0d allocations found no frame.",
                 words_sent, frames_granted, no_frame_seen);
        $display("Covered alignment edge cases, full range table, reserve, free and unknown codes.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ page_frame_bitmap_allocator.f @@
rtl/core/pfba_pkg.sv
rtl/core/pfba_word_unit.sv
rtl/core/pfba_bitmap_ram.sv
rtl/core/page_frame_bitmap_allocator.sv
tb/testbench.sv
